[rtl/rbdd_pkg.sv]
// Shared types, codes and arithmetic helpers for the rigid body derived data unit.
package rbdd_pkg;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [1:0] PH_SQ  = 2'd0;
   localparam logic [1:0] PH_ROT = 2'd1;
   localparam logic [1:0] PH_RI  = 2'd2;
   localparam logic [1:0] PH_W   = 2'd3;

   localparam logic [1:0] N_R = 2'd0;
   localparam logic [1:0] N_I = 2'd1;
   localparam logic [1:0] N_J = 2'd2;
   localparam logic [1:0] N_K = 2'd3;

   localparam logic [1:0] ROW_QUAT    = 2'd3;
   localparam logic [3:0] TENSOR_N    = 4'd9;
   localparam logic [4:0] SQRT_STEPS  = 5'd25;
   localparam logic [4:0] DIV_STEPS   = 5'd17;

   typedef struct packed {
      logic       load_en;
      logic       capture_en;
      logic       mac_en;
      logic       mac_first;
      logic       store_en;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       norm_store;
      logic       emit;
      logic [1:0] ph;
      logic [1:0] row;
      logic [1:0] col;
      logic [2:0] term;
      logic [1:0] comp;
   } cmd_type;

   typedef struct packed {
      logic       neg;
      logic [1:0] x;
      logic [1:0] y;
   } rterm_type;

   function automatic logic [2:0] mac_terms(input logic [1:0] ph);
      logic [2:0] k;
      case (ph)
         PH_SQ:   k = 3'd4;
         PH_ROT:  k = 3'd2;
         PH_RI:   k = 3'd3;
         PH_W:    k = 3'd6;
         default: k = 3'd4;
      endcase
      return k;
   endfunction

   // Each rotation entry is a constant plus two terms of the form +/-2*a*b.
   function automatic rterm_type rot_term(input logic [3:0] e, input logic t);
      rterm_type r;
      case ({e, t})
         5'd0:    r = '{1'b1, N_J, N_J};
         5'd1:    r = '{1'b1, N_K, N_K};
         5'd2:    r = '{1'b0, N_I, N_J};
         5'd3:    r = '{1'b1, N_R, N_K};
         5'd4:    r = '{1'b0, N_I, N_K};
         5'd5:    r = '{1'b0, N_R, N_J};
         5'd6:    r = '{1'b0, N_I, N_J};
         5'd7:    r = '{1'b0, N_R, N_K};
         5'd8:    r = '{1'b1, N_I, N_I};
         5'd9:    r = '{1'b1, N_K, N_K};
         5'd10:   r = '{1'b0, N_J, N_K};
         5'd11:   r = '{1'b1, N_R, N_I};
         5'd12:   r = '{1'b0, N_I, N_K};
         5'd13:   r = '{1'b1, N_R, N_J};
         5'd14:   r = '{1'b0, N_J, N_K};
         5'd15:   r = '{1'b0, N_R, N_I};
         5'd16:   r = '{1'b1, N_I, N_I};
         5'd17:   r = '{1'b1, N_J, N_J};
         default: r = '{1'b0, N_R, N_R};
      endcase
      return r;
   endfunction

   function automatic logic [1:0] idx3(input logic [1:0] v);
      return (v == 2'd3) ? 2'd0 : v;
   endfunction

   // Shift right by sixteen, rounding half away from zero.
   function automatic logic [71:0] round16(input logic [87:0] x);
      logic [87:0] y;
      y = x + (x[87] ? 88'h7FFF : 88'h8000);
      return y[87:16];
   endfunction

   function automatic logic [31:0] sat32(input logic [71:0] v);
      logic [31:0] r;
      if (v[71:31] == '0 || v[71:31] == '1) begin
         r = v[31:0];
      end else if (v[71]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

[rtl/rbdd_ctrl.sv]
// Sequencer that steps the datapath through normalisation, rotation and tensor products.
module rbdd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rbdd_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic [2:0] term_ff, term_in;
   logic [4:0] iter_ff, iter_in;
   logic [1:0] comp_ff, comp_in;
   logic [2:0] k;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      term_in  = term_ff;
      iter_in  = iter_ff;
      comp_in  = comp_ff;
      cmd      = '0;
      cmd.ph   = phase_ff;
      cmd.row  = row_ff;
      cmd.col  = col_ff;
      cmd.term = term_ff;
      cmd.comp = comp_ff;
      k        = rbdd_pkg::mac_terms(phase_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == rbdd_pkg::OP_COMPUTE) begin
                  cmd.capture_en = 1'b1;
                  state_in = ST_MAC;
                  phase_in = rbdd_pkg::PH_SQ;
                  row_in   = 2'd0;
                  col_in   = 2'd0;
                  term_in  = 3'd0;
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         ST_MAC: begin
            if (term_ff < k) begin
               cmd.mac_en    = 1'b1;
               cmd.mac_first = (term_ff == 3'd0);
            end
            if (term_ff == k + 3'd1) begin
               cmd.store_en = 1'b1;
               term_in = 3'd0;
               if (phase_ff == rbdd_pkg::PH_SQ) begin
                  state_in = ST_SQRT;
                  iter_in  = 5'd0;
               end else if (col_ff == 2'd2) begin
                  col_in = 2'd0;
                  if (row_ff == 2'd2) begin
                     row_in = 2'd0;
                     case (phase_ff)
                        rbdd_pkg::PH_ROT: phase_in = rbdd_pkg::PH_RI;
                        rbdd_pkg::PH_RI:  phase_in = rbdd_pkg::PH_W;
                        default: begin
                           phase_in = rbdd_pkg::PH_SQ;
                           state_in = ST_EMIT;
                        end
                     endcase
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         ST_SQRT: begin
            if (iter_ff == 5'd0) begin
               cmd.sqrt_init = 1'b1;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
            if (iter_ff == rbdd_pkg::SQRT_STEPS) begin
               state_in = ST_DIV;
               iter_in  = 5'd0;
               comp_in  = 2'd0;
            end else begin
               iter_in = iter_ff + 5'd1;
            end
         end
         ST_DIV: begin
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd0) begin
               cmd.div_init = 1'b1;
            end else if (iter_ff <= rbdd_pkg::DIV_STEPS) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.norm_store = 1'b1;
               iter_in = 5'd0;
               if (comp_ff == 2'd3) begin
                  state_in = ST_MAC;
                  phase_in = rbdd_pkg::PH_ROT;
                  row_in   = 2'd0;
                  col_in   = 2'd0;
                  term_in  = 3'd0;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (!rsp_stall) begin
               if (row_ff == rbdd_pkg::ROW_QUAT) begin
                  state_in = ST_IDLE;
                  row_in   = 2'd0;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= rbdd_pkg::PH_SQ;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         term_ff  <= 3'd0;
         iter_ff  <= 5'd0;
         comp_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         term_ff  <= term_in;
         iter_ff  <= iter_in;
         comp_ff  <= comp_in;
      end
   end

endmodule

[rtl/rbdd_dpath.sv]
// Datapath: shared multiplier and accumulator, root and divide steps, result registers.
module rbdd_dpath (
   input  logic                clock,
   input  logic                reset,
   input  rbdd_pkg::cmd_type   cmd,
   input  logic [3:0]          req_tensor_index,
   input  logic signed [31:0]  req_tensor_value,
   input  logic signed [15:0]  req_quat_r,
   input  logic signed [15:0]  req_quat_i,
   input  logic signed [15:0]  req_quat_j,
   input  logic signed [15:0]  req_quat_k,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   output logic [1:0]          rsp_row_index,
   output logic signed [31:0]  rsp_t_0,
   output logic signed [31:0]  rsp_t_1,
   output logic signed [31:0]  rsp_t_2,
   output logic signed [31:0]  rsp_t_3,
   output logic signed [31:0]  rsp_w_0,
   output logic signed [31:0]  rsp_w_1,
   output logic signed [31:0]  rsp_w_2,
   output logic                rsp_last
);

   logic [15:0] q_ff [4];
   logic [31:0] pos_ff [3];
   logic [31:0] tns_ff [9];
   logic [31:0] rot_ff [3][3];
   logic [49:0] ri_ff [3][3];
   logic [31:0] w_ff [3][3];
   logic [17:0] norm_ff [4];

   logic signed [65:0] prod_ff, prod_in;
   logic signed [87:0] acc_ff, acc_in, addend, base;
   logic acc_en_ff, acc_first_ff, acc_one_ff, acc_hi_ff;
   logic acc_one_in, acc_hi_in;

   logic [32:0] d_ff;
   logic [49:0] rad_ff, rad_in;
   logic [27:0] srem_ff, srem_in;
   logic [24:0] root_ff, root_in;
   logic [29:0] sq_t, sq_trial;

   logic [25:0] drem_ff, drem_in;
   logic [16:0] dnum_ff, dnum_in;
   logic [16:0] quo_ff, quo_in;
   logic        dneg_ff, dneg_in;
   logic [26:0] dv_t, dv_d;
   logic [16:0] cmag;
   logic [41:0] num;
   logic [15:0] qv;
   logic [1:0]  q_addr;
   logic [17:0] nval;

   logic signed [32:0] opa, opb;
   logic [1:0]  rot_addr, c_w, t_ri, row_g;
   logic [31:0] rot_row [3];
   logic [49:0] ri_row [3];
   logic [49:0] riv;
   logic [3:0]  ent, tns_idx;
   rbdd_pkg::rterm_type rt;
   logic [17:0] nx, ny;
   logic [32:0] nx2;
   logic [71:0] rnd;

   assign q_addr  = cmd.div_init ? cmd.comp : cmd.term[1:0];
   assign qv      = q_ff[q_addr];
   assign row_g   = rbdd_pkg::idx3(cmd.row);
   assign rot_addr = (cmd.ph == rbdd_pkg::PH_W && !cmd.emit) ? rbdd_pkg::idx3(cmd.col) : row_g;
   assign rot_row = rot_ff[rot_addr];
   assign ri_row  = ri_ff[row_g];
   assign c_w     = rbdd_pkg::idx3(cmd.term[2:1]);
   assign t_ri    = rbdd_pkg::idx3(cmd.term[1:0]);
   assign riv     = ri_row[c_w];
   assign ent     = {1'b0, cmd.row, 1'b0} + {2'b0, cmd.row} + {2'b0, cmd.col};
   assign tns_idx = {1'b0, t_ri, 1'b0} + {2'b0, t_ri} + {2'b0, cmd.col};
   assign rt      = rbdd_pkg::rot_term(ent, cmd.term[0]);
   assign nx      = norm_ff[rt.x];
   assign ny      = norm_ff[rt.y];
   assign nx2     = {{14{nx[17]}}, nx, 1'b0};

   always_comb begin
      opa        = '0;
      opb        = '0;
      acc_one_in = 1'b0;
      acc_hi_in  = 1'b0;
      case (cmd.ph)
         rbdd_pkg::PH_SQ: begin
            opa = {{17{qv[15]}}, qv};
            opb = {{17{qv[15]}}, qv};
         end
         rbdd_pkg::PH_ROT: begin
            opa = rt.neg ? -nx2 : nx2;
            opb = {{15{ny[17]}}, ny};
            acc_one_in = (cmd.row == cmd.col);
         end
         rbdd_pkg::PH_RI: begin
            opa = {rot_row[t_ri][31], rot_row[t_ri]};
            opb = (tns_idx < rbdd_pkg::TENSOR_N) ?
                  {tns_ff[tns_idx][31], tns_ff[tns_idx]} : '0;
         end
         default: begin
            opa = cmd.term[0] ? {{15{riv[49]}}, riv[49:32]} : {1'b0, riv[31:0]};
            opb = {rot_row[c_w][31], rot_row[c_w]};
            acc_hi_in = cmd.term[0];
         end
      endcase
   end

   assign prod_in = opa * opb;
   assign addend  = acc_hi_ff ? {prod_ff[55:0], 32'b0} : {{22{prod_ff[65]}}, prod_ff};
   assign base    = acc_first_ff ? (acc_one_ff ? 88'sh1_0000_0000 : 88'sh0) : acc_ff;
   assign acc_in  = base + addend;
   assign rnd     = rbdd_pkg::round16(acc_ff);

   // Square root, two radicand bits per step.
   assign sq_t     = {srem_ff, rad_ff[49:48]};
   assign sq_trial = {3'b0, root_ff, 2'b01};
   always_comb begin
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sqrt_init) begin
         rad_in  = {1'b0, d_ff, 16'b0};
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in = {rad_ff[47:0], 2'b00};
         if (sq_t >= sq_trial) begin
            srem_in = 28'(sq_t - sq_trial);
            root_in = {root_ff[23:0], 1'b1};
         end else begin
            srem_in = sq_t[27:0];
            root_in = {root_ff[23:0], 1'b0};
         end
      end
   end

   // Restoring division, one quotient bit per step.
   assign cmag = qv[15] ? (17'd0 - {1'b1, qv}) : {1'b0, qv};
   assign num  = {cmag, 25'b0} + {17'b0, root_ff};
   assign dv_t = {drem_ff, dnum_ff[16]};
   assign dv_d = {1'b0, root_ff, 1'b0};
   assign nval = dneg_ff ? (18'd0 - {1'b0, quo_ff}) : {1'b0, quo_ff};
   always_comb begin
      drem_in = drem_ff;
      dnum_in = dnum_ff;
      quo_in  = quo_ff;
      dneg_in = dneg_ff;
      if (cmd.div_init) begin
         drem_in = {1'b0, num[41:17]};
         dnum_in = num[16:0];
         quo_in  = '0;
         dneg_in = qv[15];
      end else if (cmd.div_step) begin
         dnum_in = {dnum_ff[15:0], 1'b0};
         if (dv_t >= dv_d) begin
            drem_in = 26'(dv_t - dv_d);
            quo_in  = {quo_ff[15:0], 1'b1};
         end else begin
            drem_in = dv_t[25:0];
            quo_in  = {quo_ff[15:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
         for (int n = 0; n < 9; n++) begin
            tns_ff[n] <= '0;
         end
      end else begin
         acc_en_ff <= cmd.mac_en;
         if (cmd.load_en && req_tensor_index < rbdd_pkg::TENSOR_N) begin
            tns_ff[req_tensor_index] <= req_tensor_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_first_ff <= cmd.mac_first;
      acc_one_ff   <= acc_one_in;
      acc_hi_ff    <= acc_hi_in;
      if (cmd.mac_en) begin
         prod_ff <= prod_in;
      end
      if (acc_en_ff) begin
         acc_ff <= acc_in;
      end
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      dnum_ff <= dnum_in;
      quo_ff  <= quo_in;
      dneg_ff <= dneg_in;
      if (cmd.capture_en) begin
         q_ff[0]   <= req_quat_r;
         q_ff[1]   <= req_quat_i;
         q_ff[2]   <= req_quat_j;
         q_ff[3]   <= req_quat_k;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (cmd.norm_store) begin
         if (d_ff == '0) begin
            norm_ff[cmd.comp] <= (cmd.comp == rbdd_pkg::N_R) ? 18'd65536 : 18'd0;
         end else begin
            norm_ff[cmd.comp] <= nval;
         end
      end
      if (cmd.store_en) begin
         case (cmd.ph)
            rbdd_pkg::PH_SQ:  d_ff <= acc_ff[32:0];
            rbdd_pkg::PH_ROT: rot_ff[row_g][rbdd_pkg::idx3(cmd.col)] <= rbdd_pkg::sat32(rnd);
            rbdd_pkg::PH_RI:  ri_ff[row_g][rbdd_pkg::idx3(cmd.col)] <= rnd[49:0];
            default:          w_ff[row_g][rbdd_pkg::idx3(cmd.col)] <= rbdd_pkg::sat32(rnd);
         endcase
      end
   end

   always_comb begin
      rsp_row_index = cmd.row;
      if (cmd.row == rbdd_pkg::ROW_QUAT) begin
         rsp_t_0  = {{14{norm_ff[0][17]}}, norm_ff[0]};
         rsp_t_1  = {{14{norm_ff[1][17]}}, norm_ff[1]};
         rsp_t_2  = {{14{norm_ff[2][17]}}, norm_ff[2]};
         rsp_t_3  = {{14{norm_ff[3][17]}}, norm_ff[3]};
         rsp_w_0  = '0;
         rsp_w_1  = '0;
         rsp_w_2  = '0;
         rsp_last = 1'b1;
      end else begin
         rsp_t_0  = rot_row[0];
         rsp_t_1  = rot_row[1];
         rsp_t_2  = rot_row[2];
         rsp_t_3  = pos_ff[row_g];
         rsp_w_0  = w_ff[row_g][0];
         rsp_w_1  = w_ff[row_g][1];
         rsp_w_2  = w_ff[row_g][2];
         rsp_last = 1'b0;
      end
   end

endmodule

[rtl/rigid_body_derived_data_unit.sv]
// Top level of the rigid body derived data unit: sequencer plus datapath.
//
//   channel | direction | handshake            | content
//   req_    | in        | req_valid/req_stall  | load tensor entry or compute item
//   rsp_    | out       | rsp_valid/rsp_stall  | three matrix rows, then the quaternion
//
// A load item leaves the unit idle and writes a tensor entry when its index is below nine.
// A compute item goes through the sum of squares, the square root, four 17-bit divisions
// and the rotation, R*I and W products on the one 33x33 multiplier before its first result
// shows. The four results then leave one per cycle while rsp_stall is low; a new item is
// taken in the cycle after the last result leaves. Reset clears the sequencer and the tensor.
module rigid_body_derived_data_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [3:0]         req_tensor_index,
   input  logic signed [31:0] req_tensor_value,
   input  logic signed [15:0] req_quat_r,
   input  logic signed [15:0] req_quat_i,
   input  logic signed [15:0] req_quat_j,
   input  logic signed [15:0] req_quat_k,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_t_0,
   output logic signed [31:0] rsp_t_1,
   output logic signed [31:0] rsp_t_2,
   output logic signed [31:0] rsp_t_3,
   output logic signed [31:0] rsp_w_0,
   output logic signed [31:0] rsp_w_1,
   output logic signed [31:0] rsp_w_2,
   output logic               rsp_last
);

   rbdd_pkg::cmd_type cmd;

   rbdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rbdd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_tensor_index (req_tensor_index),
      .req_tensor_value (req_tensor_value),
      .req_quat_r       (req_quat_r),
      .req_quat_i       (req_quat_i),
      .req_quat_j       (req_quat_j),
      .req_quat_k       (req_quat_k),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_row_index    (rsp_row_index),
      .rsp_t_0          (rsp_t_0),
      .rsp_t_1          (rsp_t_1),
      .rsp_t_2          (rsp_t_2),
      .rsp_t_3          (rsp_t_3),
      .rsp_w_0          (rsp_w_0),
      .rsp_w_1          (rsp_w_1),
      .rsp_w_2          (rsp_w_2),
      .rsp_last         (rsp_last)
   );

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while results are pending");

   a_row_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("result rows out of order");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid && !req_stall)
      else $error("results continue after the last item");

   a_quat_row_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_row_index == rbdd_pkg::ROW_QUAT)))
      else $error("last flag does not match the quaternion row");

endmodule

[tb/sv/tb_rigid_body_derived_data_unit.sv]
// Testbench for the rigid body derived data unit: random and directed items checked against a predictor.
module tb_rigid_body_derived_data_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  row;
      logic [31:0] t0, t1, t2, t3, w0, w1, w2;
      logic        last;
   } body_row_type;

   class derived_data_board;
      logic signed [31:0] inertia [9];
      body_row_type pending [$];
      int errors;

      function new();
         foreach (inertia[n]) inertia[n] = '0;
         errors = 0;
      endfunction

      function longint rnd_shift(longint x);
         if (x >= 0) return (x + 64'sd32768) >>> 16;
         return -((-x + 64'sd32768) >>> 16);
      endfunction

      function longint clip32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint unsigned root64(longint unsigned x);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function void note_item(logic op, logic [3:0] idx, logic signed [31:0] val,
                              logic signed [15:0] qin [4], logic signed [31:0] pos [3]);
         longint q [4], nq [4], rot [9], ri [9], w [9];
         longint unsigned d, s, mag, quo;
         longint r, i, j, k, one, acc;
         body_row_type e;
         if (op == rbdd_pkg::OP_LOAD) begin
            if (idx < rbdd_pkg::TENSOR_N) inertia[idx] = val;
            return;
         end
         d = 0;
         for (int a = 0; a < 4; a++) begin
            q[a] = qin[a];
            d += q[a] * q[a];
         end
         if (d == 0) begin
            nq[0] = 65536; nq[1] = 0; nq[2] = 0; nq[3] = 0;
         end else begin
            s = root64(d << 16);
            for (int a = 0; a < 4; a++) begin
               mag = (q[a] < 0 ? -q[a] : q[a]) << 24;
               quo = (2 * mag + s) / (2 * s);
               nq[a] = clip32(q[a] < 0 ? -longint'(quo) : longint'(quo));
            end
         end
         r = nq[0]; i = nq[1]; j = nq[2]; k = nq[3];
         one = 64'sd1 << 32;
         rot[0] = one - 2*j*j - 2*k*k;
         rot[1] = 2*i*j - 2*r*k;
         rot[2] = 2*i*k + 2*r*j;
         rot[3] = 2*i*j + 2*r*k;
         rot[4] = one - 2*i*i - 2*k*k;
         rot[5] = 2*j*k - 2*r*i;
         rot[6] = 2*i*k - 2*r*j;
         rot[7] = 2*j*k + 2*r*i;
         rot[8] = one - 2*i*i - 2*j*j;
         for (int a = 0; a < 9; a++) rot[a] = clip32(rnd_shift(rot[a]));
         for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) begin
               acc = 0;
               for (int c = 0; c < 3; c++) acc += rot[a*3+c] * longint'(inertia[c*3+b]);
               ri[a*3+b] = rnd_shift(acc);
            end
         for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) begin
               acc = 0;
               for (int c = 0; c < 3; c++) acc += ri[a*3+c] * rot[b*3+c];
               w[a*3+b] = clip32(rnd_shift(acc));
            end
         for (int a = 0; a < 3; a++) begin
            e.row = 2'(a);
            e.t0 = 32'(rot[a*3]); e.t1 = 32'(rot[a*3+1]); e.t2 = 32'(rot[a*3+2]);
            e.t3 = pos[a];
            e.w0 = 32'(w[a*3]); e.w1 = 32'(w[a*3+1]); e.w2 = 32'(w[a*3+2]);
            e.last = 1'b0;
            pending.push_back(e);
         end
         e.row = rbdd_pkg::ROW_QUAT;
         e.t0 = 32'(nq[0]); e.t1 = 32'(nq[1]); e.t2 = 32'(nq[2]); e.t3 = 32'(nq[3]);
         e.w0 = '0; e.w1 = '0; e.w2 = '0; e.last = 1'b1;
         pending.push_back(e);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         errors++;
      endfunction

      function void check_row(body_row_type g);
         body_row_type e;
         if (pending.size() == 0) begin
            report("unexpected item, row_index", 32'(g.row), '0);
            return;
         end
         e = pending.pop_front();
         if (g.row !== e.row) report("row_index", 32'(g.row), 32'(e.row));
         if (g.t0 !== e.t0) report("t_0", g.t0, e.t0);
         if (g.t1 !== e.t1) report("t_1", g.t1, e.t1);
         if (g.t2 !== e.t2) report("t_2", g.t2, e.t2);
         if (g.t3 !== e.t3) report("t_3", g.t3, e.t3);
         if (g.w0 !== e.w0) report("w_0", g.w0, e.w0);
         if (g.w1 !== e.w1) report("w_1", g.w1, e.w1);
         if (g.w2 !== e.w2) report("w_2", g.w2, e.w2);
         if (g.last !== e.last) report("last", 32'(g.last), 32'(e.last));
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_op = 0;
   logic [3:0] req_tensor_index = 0;
   logic signed [31:0] req_tensor_value = 0, req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] req_quat_r = 0, req_quat_i = 0, req_quat_j = 0, req_quat_k = 0;
   logic rsp_valid, rsp_stall = 0, rsp_last;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_t_0, rsp_t_1, rsp_t_2, rsp_t_3, rsp_w_0, rsp_w_1, rsp_w_2;
   derived_data_board board = new();
   int cycles = 0;

   always #5 clock = ~clock;

   rigid_body_derived_data_unit uut (.*);

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(3, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall)
         board.check_row('{rsp_row_index, rsp_t_0, rsp_t_1, rsp_t_2, rsp_t_3,
                           rsp_w_0, rsp_w_1, rsp_w_2, rsp_last});
   end

   // The result side stalls in bursts, with calm stretches in between.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_item(logic op, logic [3:0] idx, logic [31:0] val,
                            logic [15:0] qr, logic [15:0] qi, logic [15:0] qj, logic [15:0] qk,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      logic signed [15:0] qv [4];
      logic signed [31:0] pv [3];
      int g;
      g = ($urandom_range(0, 2) == 0) ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op; req_tensor_index <= idx; req_tensor_value <= val;
      req_quat_r <= qr; req_quat_i <= qi; req_quat_j <= qj; req_quat_k <= qk;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      qv = '{qr, qi, qj, qk};
      pv = '{px, py, pz};
      board.note_item(op, idx, val, qv, pv);
   endtask

   task automatic send_compute(logic [15:0] qr, logic [15:0] qi, logic [15:0] qj,
                               logic [15:0] qk);
      send_item(rbdd_pkg::OP_COMPUTE, 4'($urandom), $urandom, qr, qi, qj, qk,
                $urandom, $urandom, $urandom);
   endtask

   initial begin
      logic [15:0] qa, qb, qc, qd;
      repeat (5) @(posedge clock);
      reset <= 0;
      send_compute(0, 0, 0, 0);
      for (int n = 0; n < 9; n++)
         send_item(rbdd_pkg::OP_LOAD, 4'(n), (n % 4 == 0) ? 32'h0001_0000 : $urandom,
                   0, 0, 0, 0, 0, 0, 0);
      send_item(rbdd_pkg::OP_LOAD, 4'd9, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      send_item(rbdd_pkg::OP_LOAD, 4'd15, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
      send_compute(16'h1000, 0, 0, 0);
      send_compute(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_compute(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_compute(0, 0, 0, 16'h0001);
      send_compute(16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
      send_item(rbdd_pkg::OP_COMPUTE, 0, 0, 16'h0B50, 16'h0B50, 0, 0,
                32'h7FFF_FFFF, 32'h8000_0000, 0);
      for (int n = 0; n < 9; n++)
         send_item(rbdd_pkg::OP_LOAD, 4'(n), n[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                   0, 0, 0, 0, 0, 0, 0);
      send_compute(16'h7FFF, 16'h1234, 16'h8000, 16'h0100);
      for (int n = 0; n < 280; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            send_item(rbdd_pkg::OP_LOAD,
                      4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                         : $urandom_range(0, 8)),
                      ($urandom_range(0, 1)) ? $urandom : $signed($urandom_range(0, 262144))
                      - 131072, 0, 0, 0, 0, 0, 0, 0);
         end else begin
            qa = 16'($urandom); qb = 16'($urandom); qc = 16'($urandom); qd = 16'($urandom);
            case ($urandom_range(0, 4))
               0: begin qb = 0; qc = 0; qd = 0; end
               1: begin qa = 16'($urandom_range(0, 3)); qb = 0; qc = 0; qd = 0; end
               2: begin qa = qa >>> 4; qb = qb >>> 4; qc = qc >>> 4; qd = qd >>> 4; end
               default: ;
            endcase
            send_compute(qa, qb, qc, qd);
         end
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
